[rtl/core/sv32ptw_pkg.sv]
// sv32ptw_pkg: types, codes and sizes shared by the sv32 page table walker
// no dependencies; imported by every module of the walker
`timescale 1ns / 1ps

package sv32ptw_pkg;

    // command codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_PTE     = 1'b1;

    // access kinds
    localparam logic [1:0] ACC_FETCH = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;
    localparam logic [1:0] ACC_RSVD  = 2'd3;

    // privilege levels
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // result kinds
    localparam logic [1:0] RK_READ      = 2'd0;
    localparam logic [1:0] RK_WRITEBACK = 2'd1;
    localparam logic [1:0] RK_DONE      = 2'd2;
    localparam logic [1:0] RK_FAULT     = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION_ON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVILEGE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM            = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MXR            = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MPRV           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PREV_PRIVILEGE = 3'd6;

    // pte bit positions
    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W = 2;
    localparam int PTE_X = 3;
    localparam int PTE_U = 4;
    localparam int PTE_A = 6;
    localparam int PTE_D = 7;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        command;
        logic [31:0] virtual_address;
        logic [1:0]  access_kind;
        logic [31:0] pte_word;
        logic        read_error;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] address_out;
        logic [31:0] write_word;
        logic [1:0]  fault_kind;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic        translation_on;
        logic [21:0] root_page_number;
        logic [1:0]  privilege;
        logic        sum_enable;
        logic        mxr_enable;
        logic        mprv_enable;
        logic [1:0]  previous_privilege;
    } cfg_t;

    // classified item as held in the queue
    typedef struct packed {
        logic        is_request;
        logic        bypass;
        logic [31:0] vaddr;
        logic [1:0]  access;
        logic [1:0]  eff_priv;
        logic [31:0] pte;
        logic        read_error;
    } entry_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage

[rtl/core/sv32ptw_front.sv]
// sv32ptw_front: input side, classifies items and holds them in a short queue
// depends on sv32ptw_pkg
`timescale 1ns / 1ps

module sv32ptw_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sv32ptw_pkg::in_item_t in_data,
    input  sv32ptw_pkg::cfg_t     cfg,
    input  logic                  pop,
    output sv32ptw_pkg::head_t    head
);
    import sv32ptw_pkg::*;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic [1:0]       access;
    logic [1:0]       eff_priv;
    entry_t           classified;

    // kind three is handled as a load
    assign access   = (in_data.access_kind == ACC_RSVD) ? ACC_LOAD : in_data.access_kind;
    assign eff_priv = (cfg.mprv_enable && access != ACC_FETCH) ?
                      cfg.previous_privilege : cfg.privilege;

    always_comb
    begin
        classified.is_request = (in_data.command == CMD_REQUEST);
        classified.bypass     = !cfg.translation_on || eff_priv == PRIV_M;
        classified.vaddr      = in_data.virtual_address;
        classified.access     = access;
        classified.eff_priv   = eff_priv;
        classified.pte        = in_data.pte_word;
        classified.read_error = in_data.read_error;
    end

    assign in_stall = (count_reg == FULL_CNT);
    assign push     = in_valid && !in_stall;

    assign wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

endmodule

[rtl/core/sv32ptw_back.sv]
// sv32ptw_back: walk state, pte checks and result output register
// depends on sv32ptw_pkg
`timescale 1ns / 1ps

module sv32ptw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sv32ptw_pkg::cfg_t      cfg,
    input  sv32ptw_pkg::head_t     head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sv32ptw_pkg::out_item_t out_data
);
    import sv32ptw_pkg::*;

    localparam logic PH_FIRST  = 1'b0;
    localparam logic PH_SECOND = 1'b1;

    logic        busy_reg,      busy_next;
    logic [31:0] saved_addr_reg, saved_addr_next;
    logic [1:0]  saved_acc_reg, saved_acc_next;
    logic [1:0]  eff_priv_reg,  eff_priv_next;
    logic        level_reg,     level_next;
    logic [31:0] base_reg,      base_next;
    logic        phase_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    entry_t      e;
    logic [9:0]  vpn_cur;
    logic [31:0] cur_pte_addr;
    logic [31:0] root_base;
    logic [31:0] req_addr;
    logic [31:0] ptr_base;
    logic [31:0] ptr_addr;
    logic        pte_bad;
    logic        is_pointer;
    logic        user_page;
    logic        readable;
    logic        leaf_fault;
    logic [31:0] new_pte;
    logic        need_wb;
    logic [31:0] phys_addr;
    logic        emit;
    logic        final_res;
    out_item_t   res;
    logic        out_free;
    logic        step;

    assign e = head.entry;

    assign vpn_cur      = level_reg ? saved_addr_reg[31:22] : saved_addr_reg[21:12];
    assign cur_pte_addr = base_reg + {20'b0, vpn_cur, 2'b00};
    assign root_base    = {cfg.root_page_number[19:0], 12'b0};
    assign req_addr     = root_base + {20'b0, e.vaddr[31:22], 2'b00};
    assign ptr_base     = {e.pte[29:10], 12'b0};
    assign ptr_addr     = ptr_base + {20'b0, saved_addr_reg[21:12], 2'b00};

    assign pte_bad    = !e.pte[PTE_V] || (!e.pte[PTE_R] && e.pte[PTE_W]);
    assign is_pointer = !e.pte[PTE_R] && !e.pte[PTE_W] && !e.pte[PTE_X];
    assign user_page  = e.pte[PTE_U];
    assign readable   = e.pte[PTE_R] || (cfg.mxr_enable && e.pte[PTE_X]);

    // privilege, permission and superpage alignment, in walk order
    assign leaf_fault =
        (eff_priv_reg == PRIV_U && !user_page) ||
        (eff_priv_reg == PRIV_S && user_page &&
         (!cfg.sum_enable || saved_acc_reg == ACC_FETCH)) ||
        (saved_acc_reg == ACC_FETCH && !e.pte[PTE_X]) ||
        (saved_acc_reg == ACC_LOAD && !readable) ||
        (saved_acc_reg == ACC_STORE && !e.pte[PTE_W]) ||
        (level_reg && e.pte[19:10] != '0);

    always_comb
    begin
        new_pte        = e.pte;
        new_pte[PTE_A] = 1'b1;
        if (saved_acc_reg == ACC_STORE)
        begin
            new_pte[PTE_D] = 1'b1;
        end
    end

    assign need_wb   = (new_pte != e.pte);
    assign phys_addr = level_reg ? {new_pte[29:20], saved_addr_reg[21:0]}
                                 : {new_pte[29:10], saved_addr_reg[11:0]};

    always_comb
    begin
        emit            = 1'b1;
        final_res       = 1'b1;
        res             = '0;
        res.last_result = 1'b1;
        busy_next       = busy_reg;
        saved_addr_next = saved_addr_reg;
        saved_acc_next  = saved_acc_reg;
        eff_priv_next   = eff_priv_reg;
        level_next      = level_reg;
        base_next       = base_reg;
        priority if (e.is_request)
        begin
            busy_next = 1'b0;
            if (e.bypass)
            begin
                res.result_kind = RK_DONE;
                res.address_out = e.vaddr;
            end
            else
            begin
                busy_next       = 1'b1;
                saved_addr_next = e.vaddr;
                saved_acc_next  = e.access;
                eff_priv_next   = e.eff_priv;
                level_next      = 1'b1;
                base_next       = root_base;
                res.result_kind = RK_READ;
                res.address_out = req_addr;
            end
        end
        else if (!busy_reg)
        begin
            // stray pte data, dropped
            emit = 1'b0;
        end
        else if (e.read_error || pte_bad || (is_pointer && !level_reg) ||
                 (!is_pointer && leaf_fault))
        begin
            busy_next       = 1'b0;
            res.result_kind = RK_FAULT;
            res.fault_kind  = saved_acc_reg;
        end
        else if (is_pointer)
        begin
            base_next       = ptr_base;
            level_next      = 1'b0;
            res.result_kind = RK_READ;
            res.address_out = ptr_addr;
        end
        else if (need_wb && phase_reg == PH_FIRST)
        begin
            final_res       = 1'b0;
            res.result_kind = RK_WRITEBACK;
            res.address_out = cur_pte_addr;
            res.write_word  = new_pte;
            res.last_result = 1'b0;
        end
        else
        begin
            busy_next       = 1'b0;
            res.result_kind = RK_DONE;
            res.address_out = phys_addr;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = head.valid && (!emit || out_free);
    assign pop      = step && final_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            saved_addr_reg <= '0;
            saved_acc_reg  <= '0;
            eff_priv_reg   <= '0;
            level_reg      <= 1'b1;
            base_reg       <= '0;
            phase_reg      <= PH_FIRST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg       <= busy_next;
                saved_addr_reg <= saved_addr_next;
                saved_acc_reg  <= saved_acc_next;
                eff_priv_reg   <= eff_priv_next;
                level_reg      <= level_next;
                base_reg       <= base_next;
                phase_reg      <= PH_FIRST;
            end
            else if (step)
            begin
                phase_reg <= PH_SECOND;
            end

            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/core/sv32_page_table_walker_core.sv]
// sv32_page_table_walker_core: items are registered in the queue, results in the output register
// throughput one item per cycle unless stalled, set by two-entry queue and single output reg
// a leaf pte that needs an a/d update yields two results from one item, write-back then done
// reset: walk idle at level one, queue and output empty, satp mode off, privilege machine
// no clearing pass; the block takes items in the first cycle after reset
// depends on sv32ptw_pkg, sv32ptw_front, sv32ptw_back
`timescale 1ns / 1ps

module sv32_page_table_walker_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // item input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  sv32ptw_pkg::in_item_t              in_data,
    // result output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output sv32ptw_pkg::out_item_t             out_data,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sv32ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                        cfg_data
);
    import sv32ptw_pkg::*;

    // register values after reset: bare mode, machine privilege
    localparam cfg_t CFG_RESET = '{1'b0, 22'd0, PRIV_M, 1'b0, 1'b0, 1'b0, PRIV_U};

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  cfg_write;
    head_t head;
    logic  pop;

    // config writes are always taken; the user must write only while the walker is idle, unenforced
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (cfg_index)
            CFG_TRANSLATION_ON: cfg_next.translation_on     = cfg_data[0];
            CFG_ROOT_PAGE:      cfg_next.root_page_number   = cfg_data[21:0];
            CFG_PRIVILEGE:      cfg_next.privilege          = cfg_data[1:0];
            CFG_SUM:            cfg_next.sum_enable         = cfg_data[0];
            CFG_MXR:            cfg_next.mxr_enable         = cfg_data[0];
            CFG_MPRV:           cfg_next.mprv_enable        = cfg_data[0];
            CFG_PREV_PRIVILEGE: cfg_next.previous_privilege = cfg_data[1:0];
            default:            cfg_next                    = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify each transfer (effective privilege, bypass) and queue it
    sv32ptw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .pop      (pop),
        .head     (head)
    );

    // back: run the walk on the queue head and drive the output register
    sv32ptw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // the back end never retires an item the queue does not hold
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop with empty queue");

    // a full queue always presents a head to the back end
    a_stall_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> head.valid)
        else $error("input stalled with empty queue");

    // a write-back transfer is followed at once by the translation result
    a_wb_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.result_kind == RK_WRITEBACK)
        |=> (out_valid && out_data.result_kind == RK_DONE && out_data.last_result))
        else $error("write-back not followed by done");

endmodule

[tb/sv/sv32_walk_checker.sv]
// sv32_walk_checker: watches the item, result and register channels of the sv32 walker,
// predicts every result from its own copy of the walk state and compares in order
// depends on sv32ptw_pkg for the payload structs, codes and register indexes
`timescale 1ns / 1ps

module sv32_walk_checker
    import sv32ptw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   mismatch_count,
    output int                   results_pending
);

    cfg_t        settings;
    logic        walk_active;
    logic [31:0] walk_vaddr;
    logic [1:0]  walk_access;
    logic [1:0]  walk_priv;
    logic        walk_top;
    logic [31:0] walk_table;
    out_item_t   awaited_results[$];

    // address of the pte for the current level
    function automatic logic [31:0] entry_address();
        logic [9:0] vpn;
        vpn = walk_top ? walk_vaddr[31:22] : walk_vaddr[21:12];
        return walk_table + {20'd0, vpn, 2'b00};
    endfunction

    task automatic await_result(input logic [1:0] kind, input logic [31:0] addr,
                                input logic [31:0] word, input logic [1:0] fkind,
                                input logic last);
        out_item_t r;
        r.result_kind = kind;
        r.address_out = addr;
        r.write_word  = word;
        r.fault_kind  = fkind;
        r.last_result = last;
        awaited_results.push_back(r);
    endtask

    task automatic page_fault();
        walk_active = 1'b0;
        await_result(RK_FAULT, 32'd0, 32'd0, walk_access, 1'b1);
    endtask

    task automatic predict_walk(input in_item_t item);
        logic [1:0]  acc;
        logic [1:0]  eff;
        logic [31:0] pte;
        logic [31:0] updated;
        logic [31:0] paddr;
        logic        user_page;
        logic        readable;
        logic        denied;
        acc = (item.access_kind == ACC_RSVD) ? ACC_LOAD : item.access_kind;
        pte = item.pte_word;
        if (item.command == CMD_REQUEST) begin
            eff = (settings.mprv_enable && acc != ACC_FETCH) ?
                  settings.previous_privilege : settings.privilege;
            walk_active = 1'b0;
            if (!settings.translation_on || eff == PRIV_M) begin
                await_result(RK_DONE, item.virtual_address, 32'd0, ACC_FETCH, 1'b1);
            end
            else begin
                walk_active = 1'b1;
                walk_vaddr  = item.virtual_address;
                walk_access = acc;
                walk_priv   = eff;
                walk_top    = 1'b1;
                walk_table  = {settings.root_page_number[19:0], 12'd0};
                await_result(RK_READ, entry_address(), 32'd0, ACC_FETCH, 1'b1);
            end
        end
        else if (walk_active) begin
            if (item.read_error || !pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W])) begin
                page_fault();
            end
            else if (!pte[PTE_R] && !pte[PTE_X]) begin
                // pointer to the next level
                if (!walk_top) begin
                    page_fault();
                end
                else begin
                    walk_table = {pte[29:10], 12'd0};
                    walk_top   = 1'b0;
                    await_result(RK_READ, entry_address(), 32'd0, ACC_FETCH, 1'b1);
                end
            end
            else begin
                user_page = pte[PTE_U];
                readable  = pte[PTE_R] || (settings.mxr_enable && pte[PTE_X]);
                denied    = (walk_priv == PRIV_U && !user_page)
                         || (walk_priv == PRIV_S && user_page
                             && (!settings.sum_enable || walk_access == ACC_FETCH))
                         || (walk_access == ACC_FETCH && !pte[PTE_X])
                         || (walk_access == ACC_LOAD && !readable)
                         || (walk_access == ACC_STORE && !pte[PTE_W])
                         || (walk_top && pte[19:10] != 10'd0);
                if (denied) begin
                    page_fault();
                end
                else begin
                    updated = pte;
                    updated[PTE_A] = 1'b1;
                    if (walk_access == ACC_STORE)
                        updated[PTE_D] = 1'b1;
                    if (updated != pte)
                        await_result(RK_WRITEBACK, entry_address(), updated, ACC_FETCH, 1'b0);
                    paddr = walk_top ? {updated[29:20], walk_vaddr[21:0]}
                                     : {updated[29:10], walk_vaddr[11:0]};
                    walk_active = 1'b0;
                    await_result(RK_DONE, paddr, 32'd0, ACC_FETCH, 1'b1);
                end
            end
        end
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : tracker
        out_item_t want;
        if (!rst_n) begin
            settings.translation_on     = 1'b0;
            settings.root_page_number   = 22'd0;
            settings.privilege          = PRIV_M;
            settings.sum_enable         = 1'b0;
            settings.mxr_enable         = 1'b0;
            settings.mprv_enable        = 1'b0;
            settings.previous_privilege = PRIV_U;
            walk_active     = 1'b0;
            walk_vaddr      = 32'd0;
            walk_access     = ACC_FETCH;
            walk_priv       = PRIV_U;
            walk_top        = 1'b1;
            walk_table      = 32'd0;
            awaited_results.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with none awaited, expected none, actual %h",
                             $time, out_data);
                    mismatch_count++;
                end
                else begin
                    want = awaited_results.pop_front();
                    compare_field("result_kind", 32'(want.result_kind),
                                  32'(out_data.result_kind));
                    compare_field("address_out", want.address_out, out_data.address_out);
                    compare_field("write_word", want.write_word, out_data.write_word);
                    compare_field("fault_kind", 32'(want.fault_kind),
                                  32'(out_data.fault_kind));
                    compare_field("last_result", 32'(want.last_result),
                                  32'(out_data.last_result));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TRANSLATION_ON: settings.translation_on     = cfg_data[0];
                    CFG_ROOT_PAGE:      settings.root_page_number   = cfg_data[21:0];
                    CFG_PRIVILEGE:      settings.privilege          = cfg_data[1:0];
                    CFG_SUM:            settings.sum_enable         = cfg_data[0];
                    CFG_MXR:            settings.mxr_enable         = cfg_data[0];
                    CFG_MPRV:           settings.mprv_enable        = cfg_data[0];
                    CFG_PREV_PRIVILEGE: settings.previous_privilege = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_walk(in_data);
            results_pending = awaited_results.size();
        end
    end

endmodule

[tb/sv/sv32_page_table_walker_core_tb.sv]
// sv32_page_table_walker_core_tb: drives translate requests and pte words into the walker
// under changing satp/mstatus settings and idle patterns; the checker judges every result
// depends on sv32ptw_pkg, sv32_page_table_walker_core and sv32_walk_checker
`timescale 1ns / 1ps

module sv32_page_table_walker_core_tb;
    import sv32ptw_pkg::*;

    // reserved privilege encoding, translated with no user-page checks
    localparam logic [1:0] PRIV_RSVD = 2'd2;
    // longest stretch with no transfer on any channel before the run is declared hung;
    // the deliberate receiver hold-off is set by HOLD_CYCLES, everything else is far shorter
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    // margin after the last result, covers pte words still draining with no result
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 120;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int         mismatch_count;
    int         results_pending;
    int         items_sent = 0;
    int         quiet_cycles = 0;
    idle_mode_t idle_mode = IDLE_NONE;

    // receiver hold-off: the stimulus flips hold_toggle, the receiver counts the cycles
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    // settings as last written, used only to shape the walks
    logic       cur_on = 1'b0;
    logic [1:0] cur_priv = PRIV_M;
    logic       cur_sum = 1'b0;
    logic       cur_mprv = 1'b0;
    logic [1:0] cur_mpp = PRIV_U;

    sv32_page_table_walker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sv32_walk_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int sender_idle_pct(input idle_mode_t m);
        return (m == IDLE_SENDER) ? 72 : (m == IDLE_BOTH) ? 21 : 0;
    endfunction

    function automatic int receiver_stall_pct(input idle_mode_t m);
        return (m == IDLE_RECEIVER) ? 72 : (m == IDLE_BOTH) ? 21 : 0;
    endfunction

    // result side: random stall per mode, or a long hold-off when asked for one
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct(idle_mode));
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // item builders; the fields a command does not use still get random bits
    function automatic in_item_t request_item(input logic [31:0] va, input logic [1:0] acc);
        in_item_t it;
        it.command         = CMD_REQUEST;
        it.virtual_address = va;
        it.access_kind     = acc;
        it.pte_word        = $urandom;
        it.read_error      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t pte_item(input logic [31:0] pte, input logic rerr);
        in_item_t it;
        it.command         = CMD_PTE;
        it.virtual_address = $urandom;
        it.access_kind     = 2'($urandom_range(0, 3));
        it.pte_word        = pte;
        it.read_error      = rerr;
        return it;
    endfunction

    // offer one item and hold it until the transfer; idling is decided only before
    // the item goes up, so a stalled item never changes or drops
    task automatic offer_item(input in_item_t item);
        bit offered;
        bit accepted;
        offered  = 1'b0;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            if (!offered)
            begin
                if ($urandom_range(0, 99) < sender_idle_pct(idle_mode))
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= item;
                    offered  = 1'b1;
                end
            end
            @(posedge clk);
            if (offered && in_valid && !in_stall)
                accepted = 1'b1;
        end
    endtask

    task automatic send_request(input logic [31:0] va, input logic [1:0] acc);
        offer_item(request_item(va, acc));
        items_sent++;
    endtask

    task automatic send_pte(input logic [31:0] pte, input logic rerr);
        offer_item(pte_item(pte, rerr));
        items_sent++;
    endtask

    // register write with random junk above the register's width
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        int w;
        case (idx)
            CFG_ROOT_PAGE:                     w = 22;
            CFG_PRIVILEGE, CFG_PREV_PRIVILEGE: w = 2;
            default:                           w = 1;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ($urandom << w) | value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic on, input logic [21:0] root,
                                  input logic [1:0] priv, input logic sum, input logic mxr,
                                  input logic mprv, input logic [1:0] mpp);
        write_register(CFG_TRANSLATION_ON, {31'd0, on});
        write_register(CFG_ROOT_PAGE, {10'd0, root});
        write_register(CFG_PRIVILEGE, {30'd0, priv});
        write_register(CFG_SUM, {31'd0, sum});
        write_register(CFG_MXR, {31'd0, mxr});
        write_register(CFG_MPRV, {31'd0, mprv});
        write_register(CFG_PREV_PRIVILEGE, {30'd0, mpp});
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_on   = on;
        cur_priv = priv;
        cur_sum  = sum;
        cur_mprv = mprv;
        cur_mpp  = mpp;
    endtask

    // stop offering, let every awaited result arrive, then give trailing items time
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // non-leaf pte: valid, no r/w/x, everything else random
    function automatic logic [31:0] pointer_pte();
        logic [31:0] pte;
        pte = $urandom;
        pte[3:0] = 4'b0001;
        return pte;
    endfunction

    // leaf pte, mostly shaped to pass the permission checks so walks reach the end
    function automatic logic [31:0] leaf_pte(input logic [1:0] acc, input logic [1:0] eff,
                                             input logic top);
        logic [31:0] pte;
        pte = $urandom;
        pte[PTE_V] = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 9) < 7)
        begin
            case (acc)
                ACC_FETCH: pte[PTE_X] = 1'b1;
                ACC_STORE: {pte[PTE_W], pte[PTE_R]} = 2'b11;
                default:   pte[PTE_R] = 1'b1;
            endcase
            pte[PTE_U] = (eff == PRIV_U) ? 1'b1 : (cur_sum && $urandom_range(0, 3) == 0);
        end
        // keep it a leaf
        if (pte[3:1] == 3'b000)
            pte[PTE_R] = 1'b1;
        // superpages are mostly aligned
        if (top && $urandom_range(0, 4) != 0)
            pte[19:10] = 10'd0;
        return pte;
    endfunction

    // one walk: request, first-level pte, and a second-level pte after a pointer;
    // a few walks are replaced mid-flight, left hanging or fed garbage
    task automatic run_walk();
        logic [31:0] va;
        logic [1:0]  acc;
        logic [1:0]  eff;
        logic [31:0] pte;
        logic        rerr;
        va  = $urandom;
        acc = ($urandom_range(0, 15) == 0) ? ACC_RSVD : 2'($urandom_range(0, 2));
        send_request(va, acc);
        if ($urandom_range(0, 24) == 0)
        begin
            // a second request drops the first walk
            va  = $urandom;
            acc = 2'($urandom_range(0, 3));
            send_request(va, acc);
        end
        if (acc == ACC_RSVD)
            acc = ACC_LOAD;
        eff = (cur_mprv && acc != ACC_FETCH) ? cur_mpp : cur_priv;
        if (cur_on && eff != PRIV_M)
        begin
            rerr = ($urandom_range(0, 19) == 0);
            pte  = $urandom_range(0, 1) ? pointer_pte() : leaf_pte(acc, eff, 1'b1);
            if ($urandom_range(0, 19) == 0)
                pte = $urandom;
            send_pte(pte, rerr);
            if (!rerr && pte[PTE_V] && pte[3:1] == 3'b000 && $urandom_range(0, 19) != 0)
            begin
                rerr = ($urandom_range(0, 29) == 0);
                pte  = ($urandom_range(0, 9) == 0) ? pointer_pte() : leaf_pte(acc, eff, 1'b0);
                send_pte(pte, rerr);
            end
        end
    endtask

    initial
    begin
        int goal;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TRANSLATION_ON;
        cfg_data  = 32'd0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bare mode straight out of reset: address passes through for every access kind
        send_request(32'h0000_0000, ACC_FETCH);
        send_request(32'hFFFF_FFFF, ACC_LOAD);
        send_request(32'h8000_0000, ACC_STORE);
        send_request(32'h7FFF_FFFF, ACC_RSVD);
        // pte word with no walk in flight is dropped
        offer_item(pte_item(32'hFFFF_FFFF, 1'b1));
        settle();

        // supervisor, sum and mxr on, root page at the top of the range
        apply_settings(1'b1, 22'h3F_FFFF, PRIV_S, 1'b1, 1'b1, 1'b0, PRIV_U);
        // two-level walk, all-ones pointer, leaf with a already set: no write-back
        send_request(32'hFFFF_FFFF, ACC_LOAD);
        send_pte(32'hFFFF_FC01, 1'b0);
        send_pte(32'hFFFF_FC43, 1'b0);
        // aligned superpage store: write-back sets a and d
        send_request(32'h0000_0000, ACC_STORE);
        send_pte(32'hFFF0_0007, 1'b0);
        // misaligned superpage faults before any write-back
        send_request(32'h1234_5678, ACC_LOAD);
        send_pte(32'h0000_0403, 1'b0);
        // bus error on the pte read
        send_request(32'hDEAD_BEEF, ACC_FETCH);
        send_pte(32'h0000_00CF, 1'b1);
        // w without r
        send_request(32'h0040_1000, ACC_STORE);
        send_pte(32'h0000_0005, 1'b0);
        // invalid pte
        send_request(32'h0000_1000, ACC_LOAD);
        send_pte(32'h0000_0000, 1'b0);
        // pointer at the last level
        send_request(32'h0080_2000, ACC_LOAD);
        send_pte(32'h0000_0001, 1'b0);
        send_pte(32'h0000_0401, 1'b0);
        // supervisor fetch from a user page faults even with sum
        send_request(32'h0000_3000, ACC_FETCH);
        send_pte(32'h0000_0059, 1'b0);
        // execute-only page readable through mxr
        send_request(32'h0000_4000, ACC_LOAD);
        send_pte(32'h0000_0049, 1'b0);
        // new request while a walk is open replaces it
        send_request(32'h0123_4567, ACC_LOAD);
        send_request(32'h89AB_CDEF, ACC_STORE);
        send_pte(32'h0000_00C7, 1'b0);
        // access kind three behaves as a load
        send_request(32'h0000_5000, ACC_RSVD);
        send_pte(32'h0000_0003, 1'b0);
        settle();

        // random phases, each with its own settings and idle pattern
        goal = items_sent;
        for (int phase = 1; phase <= 11; phase++)
        begin
            case (phase)
                1: apply_settings(1'b1, 22'd0, PRIV_U, 1'b0, 1'b0, 1'b0, PRIV_U);
                2: apply_settings(1'b1, 22'($urandom), PRIV_S, 1'b0, 1'b1, 1'b0, PRIV_U);
                3: apply_settings(1'b1, 22'h3F_FFFF, PRIV_S, 1'b1, 1'b1, 1'b0, PRIV_S);
                4: apply_settings(1'b1, 22'($urandom), PRIV_RSVD, 1'b0, 1'b0, 1'b0, PRIV_U);
                // mprv to user: loads and stores translate, fetches pass through
                5: apply_settings(1'b1, 22'($urandom), PRIV_M, 1'b0, 1'b0, 1'b1, PRIV_U);
                // mprv to machine: loads and stores pass through
                6: apply_settings(1'b1, 22'($urandom), PRIV_S, 1'b1, 1'b0, 1'b1, PRIV_M);
                7: apply_settings(1'b0, 22'($urandom), PRIV_U, 1'b1, 1'b1, 1'b1, PRIV_S);
                default:
                    apply_settings($urandom_range(0, 7) != 0, 22'($urandom),
                                   2'($urandom_range(0, 3)), 1'($urandom),
                                   1'($urandom), 1'($urandom), 2'($urandom_range(0, 3)));
            endcase
            idle_mode = idle_mode_t'(phase % 4);
            // long receiver hold-off while the sender keeps pushing: fills the block
            if (phase == 3)
                hold_toggle <= ~hold_toggle;
            goal += PHASE_ITEMS;
            while (items_sent < goal)
            begin
                run_walk();
                if ($urandom_range(0, 24) == 0)
                    offer_item(pte_item($urandom, 1'($urandom)));
            end
            settle();
        end

        if (mismatch_count == 0 && results_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
